>>> rtl/dqne_pkg.sv
// dqne_pkg: shared types and constants for the DNS query name extractor.
// No dependencies; used by the channel interfaces, the parse core and the top level.
package dqne_pkg;

   typedef enum logic [1:0] {
      KIND_CHAR    = 2'd0,
      KIND_ACCEPT  = 2'd1,
      KIND_DISCARD = 2'd2
   } result_kind_type;

   localparam logic [15:0] DNS_PORT_RESET = 16'd53;
   localparam logic [15:0] MIN_DGRAM_LEN  = 16'd13;
   localparam logic [3:0]  HEADER_BYTES   = 4'd12;
   localparam logic [3:0]  FLAGS_OFFSET   = 4'd2;
   localparam logic [3:0]  QDCNT_HI_OFFSET = 4'd4;
   localparam logic [3:0]  QDCNT_LO_OFFSET = 4'd5;
   localparam logic [7:0]  MAX_LABEL_LEN  = 8'd63;
   localparam logic [7:0]  DOT_CHAR       = 8'h2E;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic        last_byte;
      logic [15:0] dest_port;
      logic [15:0] datagram_length;
   } req_payload_type;

   typedef struct packed {
      result_kind_type result_kind;
      logic [7:0]      name_char;
      logic [7:0]      name_length;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } core_result_type;

endpackage

>>> rtl/dqne_req_if.sv
// dqne_req_if: valid/ready channel carrying one datagram byte per transaction.
// Depends on dqne_pkg for the payload type.
interface dqne_req_if;
   logic                     valid;
   logic                     ready;
   dqne_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/dqne_rsp_if.sv
// dqne_rsp_if: valid/ready channel carrying one name result per transaction.
// Depends on dqne_pkg for the payload type.
interface dqne_rsp_if;
   logic                     valid;
   logic                     ready;
   dqne_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/dqne_parse_core.sv
// dqne_parse_core: parse state registers and the per-byte next-state and result logic.
// Depends on dqne_pkg. Advances only when step is high.
module dqne_parse_core #(
   parameter int NAME_BYTES = 254,
   parameter int MAX_LABELS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  dqne_pkg::req_payload_type item,
   input  logic [15:0]               dns_port,
   output dqne_pkg::core_result_type result
);

   localparam int NCW = $clog2(NAME_BYTES);
   localparam int LCW = $clog2(MAX_LABELS + 1);
   localparam logic [NCW-1:0] NAME_LIMIT  = NCW'(NAME_BYTES - 1);
   localparam logic [LCW-1:0] LABEL_LIMIT = LCW'(MAX_LABELS);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_LEN,
      PH_CHARS
   } phase_type;

   phase_type      phase_ff, phase_in;
   logic [3:0]     hoff_ff, hoff_in;
   logic [7:0]     qdh_ff, qdh_in;
   logic [5:0]     lrem_ff, lrem_in;
   logic [NCW-1:0] ncnt_ff, ncnt_in;
   logic [LCW-1:0] lcnt_ff, lcnt_in;

   always_comb begin
      logic do_len;
      do_len   = 1'b0;
      phase_in = phase_ff;
      hoff_in  = hoff_ff;
      qdh_in   = qdh_ff;
      lrem_in  = lrem_ff;
      ncnt_in  = ncnt_ff;
      lcnt_in  = lcnt_ff;
      result   = '0;

      if (item.first_byte) begin
         // close out a name abandoned without its last byte
         if (phase_ff == PH_LEN || phase_ff == PH_CHARS) begin
            result.valid               = 1'b1;
            result.payload.result_kind = dqne_pkg::KIND_DISCARD;
            result.payload.name_length = 8'(ncnt_ff);
         end
         hoff_in = '0;
         qdh_in  = '0;
         lrem_in = '0;
         ncnt_in = '0;
         lcnt_in = '0;
         phase_in = (item.dest_port == dns_port &&
                     item.datagram_length >= dqne_pkg::MIN_DGRAM_LEN) ? PH_HEADER : PH_IDLE;
      end

      unique case (phase_in)
         PH_HEADER: begin
            if (hoff_in < dqne_pkg::HEADER_BYTES) begin
               if (hoff_in == dqne_pkg::FLAGS_OFFSET && item.data_byte[7]) begin
                  phase_in = PH_IDLE;
               end
               if (hoff_in == dqne_pkg::QDCNT_HI_OFFSET) begin
                  qdh_in = item.data_byte;
               end
               if (hoff_in == dqne_pkg::QDCNT_LO_OFFSET && qdh_in == 8'd0 &&
                   item.data_byte == 8'd0) begin
                  phase_in = PH_IDLE;
               end
               hoff_in = hoff_in + 4'd1;
               if (item.last_byte) begin
                  phase_in = PH_IDLE;
               end
            end else if (item.data_byte == 8'd0) begin
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_LEN;
               do_len   = 1'b1;
            end
         end
         PH_LEN: begin
            do_len = 1'b1;
         end
         PH_CHARS: begin
            if (item.last_byte || ncnt_in >= NAME_LIMIT) begin
               phase_in                   = PH_IDLE;
               result.valid               = 1'b1;
               result.payload.result_kind = dqne_pkg::KIND_DISCARD;
               result.payload.name_length = 8'(ncnt_in);
            end else begin
               ncnt_in = ncnt_in + 1'b1;
               lrem_in = lrem_in - 6'd1;
               if (lrem_in == 6'd0) begin
                  phase_in = PH_LEN;
               end
               result.valid               = 1'b1;
               result.payload.result_kind = dqne_pkg::KIND_CHAR;
               result.payload.name_char   = item.data_byte;
               result.payload.name_length = 8'(ncnt_in);
            end
         end
         PH_IDLE: begin
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // label length byte; the terminating zero accepts ahead of the length checks
      if (do_len) begin
         priority if (lcnt_in >= LABEL_LIMIT) begin
            phase_in                   = PH_IDLE;
            result.valid               = 1'b1;
            result.payload.result_kind = dqne_pkg::KIND_DISCARD;
            result.payload.name_length = 8'(ncnt_in);
         end else if (item.data_byte == 8'd0) begin
            phase_in                   = PH_IDLE;
            result.valid               = 1'b1;
            result.payload.result_kind = dqne_pkg::KIND_ACCEPT;
            result.payload.name_length = 8'(ncnt_in);
         end else if (item.data_byte > dqne_pkg::MAX_LABEL_LEN ||
                      (ncnt_in != '0 && ncnt_in >= NAME_LIMIT) || item.last_byte) begin
            phase_in                   = PH_IDLE;
            result.valid               = 1'b1;
            result.payload.result_kind = dqne_pkg::KIND_DISCARD;
            result.payload.name_length = 8'(ncnt_in);
         end else begin
            lcnt_in  = lcnt_in + 1'b1;
            lrem_in  = item.data_byte[5:0];
            phase_in = PH_CHARS;
            if (ncnt_in != '0) begin
               ncnt_in                    = ncnt_in + 1'b1;
               result.valid               = 1'b1;
               result.payload.result_kind = dqne_pkg::KIND_CHAR;
               result.payload.name_char   = dqne_pkg::DOT_CHAR;
               result.payload.name_length = 8'(ncnt_in);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hoff_ff  <= '0;
         qdh_ff   <= '0;
         lrem_ff  <= '0;
         ncnt_ff  <= '0;
         lcnt_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         hoff_ff  <= hoff_in;
         qdh_ff   <= qdh_in;
         lrem_ff  <= lrem_in;
         ncnt_ff  <= ncnt_in;
         lcnt_ff  <= lcnt_in;
      end
   end

endmodule

>>> rtl/dns_query_name_extractor_unit.sv
// dns_query_name_extractor_unit: top level with input register, parse core and result register.
// Depends on dqne_pkg, dqne_req_if, dqne_rsp_if and dqne_parse_core.
//
//   channel   direction  transaction
//   req_bus   in         one UDP payload byte with datagram framing
//   rsp_bus   out        one name character, or the accept/discard mark for the name
//   csr_*     in         write of the DNS port register
//
// A byte is loaded into the input register on its transaction edge and parsed from that
// register; the result register loads when the parse step is taken, so a result passes the
// input register and then the result register before it is offered.
// One byte per cycle is sustained while rsp_bus.ready is high; the single parse
// state update per byte sets that figure.
// A held result stalls the parse step, and the input register then fills and drops ready.
// Reset is synchronous and returns the DNS port to 53 and the parser to idle.
module dns_query_name_extractor_unit #(
   parameter int NAME_BYTES = 254,
   parameter int MAX_LABELS = 64
) (
   input  logic              clock,
   input  logic              reset,
   dqne_req_if.sink          req_bus,
   dqne_rsp_if.source        rsp_bus,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data
);

   logic [15:0]               dns_port_ff;
   logic                      in_valid_ff, in_valid_in;
   dqne_pkg::req_payload_type in_payload_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   dqne_pkg::rsp_payload_type rsp_payload_ff;
   dqne_pkg::core_result_type core_result;
   logic                      out_free;
   logic                      step;
   logic                      req_take;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign step     = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || step;
   assign req_take = req_bus.valid && req_bus.ready;

   assign in_valid_in  = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = step ? core_result.valid : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   dqne_parse_core #(
      .NAME_BYTES (NAME_BYTES),
      .MAX_LABELS (MAX_LABELS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .item     (in_payload_ff),
      .dns_port (dns_port_ff),
      .result   (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dns_port_ff  <= dqne_pkg::DNS_PORT_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            dns_port_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: load on transaction, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_payload_ff <= req_bus.payload;
      end
      if (step) begin
         rsp_payload_ff <= core_result.payload;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_payload_ff;

endmodule

>>> rtl/dqne_checker.sv
// dqne_checker: port-level assertions for the DNS query name extractor.
// Depends on dqne_pkg; bound to dns_query_name_extractor_unit at the end of this file.
module dqne_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input dqne_pkg::rsp_payload_type rsp_payload
);

   // no result may survive reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // hold a stalled result
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or dropped");

   a_mark_has_no_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_kind != dqne_pkg::KIND_CHAR |->
         rsp_payload.name_char == 8'd0)
      else $error("accept or discard result carries a character");

   a_char_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_kind == dqne_pkg::KIND_CHAR |->
         rsp_payload.name_length != 8'd0)
      else $error("character result with zero name length");

endmodule

bind dns_query_name_extractor_unit dqne_checker u_dqne_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);

>>> verif/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for dns_query_name_extractor_unit, with a scoreboard class
// that predicts name results per accepted byte. Depends on dqne_pkg, dqne_req_if and dqne_rsp_if.
module testbench;

   localparam int NAME_BYTES   = 254;
   localparam int MAX_LABELS   = 64;
   localparam int ITEM_TARGET  = 1650;
   localparam int QUIET_CYCLES = 10;
   localparam int LONG_HOLD    = 400;

   typedef enum logic [1:0] {
      S_IDLE, S_HEADER, S_LEN, S_CHARS
   } parse_state_type;

   class name_scoreboard;
      dqne_pkg::rsp_payload_type expected_q[$];
      int                        errors;
      logic [15:0]               port;
      parse_state_type           phase;
      logic [3:0]                hdr_off;
      logic [7:0]                qd_hi;
      int                        label_left;
      int                        name_len;
      int                        label_cnt;

      function new();
         errors     = 0;
         port       = dqne_pkg::DNS_PORT_RESET;
         phase      = S_IDLE;
         hdr_off    = '0;
         qd_hi      = '0;
         label_left = 0;
         name_len   = 0;
         label_cnt  = 0;
      endfunction

      function void push_result(dqne_pkg::result_kind_type k, logic [7:0] c, int len);
         dqne_pkg::rsp_payload_type e;
         e.result_kind = k;
         e.name_char   = c;
         e.name_length = len[7:0];
         expected_q.push_back(e);
      endfunction

      function void close_name(dqne_pkg::result_kind_type k);
         phase = S_IDLE;
         push_result(k, 8'h00, name_len);
      endfunction

      function void take_length(logic [7:0] b, logic last);
         if (label_cnt >= MAX_LABELS) begin
            close_name(dqne_pkg::KIND_DISCARD);
         end else if (b == 8'h00) begin
            close_name(dqne_pkg::KIND_ACCEPT);
         end else if (b > dqne_pkg::MAX_LABEL_LEN ||
                      (name_len != 0 && name_len >= NAME_BYTES - 1)) begin
            close_name(dqne_pkg::KIND_DISCARD);
         end else if (last) begin
            close_name(dqne_pkg::KIND_DISCARD);
         end else begin
            label_cnt++;
            label_left = int'(b);
            phase = S_CHARS;
            // separator goes out with every label length but the first
            if (name_len != 0) begin
               name_len++;
               push_result(dqne_pkg::KIND_CHAR, dqne_pkg::DOT_CHAR, name_len);
            end
         end
      endfunction

      function void note_byte(dqne_pkg::req_payload_type r);
         if (r.first_byte) begin
            // abandon a name that never saw its end
            if (phase == S_LEN || phase == S_CHARS)
               push_result(dqne_pkg::KIND_DISCARD, 8'h00, name_len);
            hdr_off    = '0;
            qd_hi      = '0;
            label_left = 0;
            name_len   = 0;
            label_cnt  = 0;
            if (r.dest_port == port && r.datagram_length >= dqne_pkg::MIN_DGRAM_LEN)
               phase = S_HEADER;
            else phase = S_IDLE;
         end
         case (phase)
            S_HEADER: begin
               if (hdr_off < dqne_pkg::HEADER_BYTES) begin
                  if (hdr_off == dqne_pkg::FLAGS_OFFSET && r.data_byte[7]) phase = S_IDLE;
                  if (hdr_off == dqne_pkg::QDCNT_HI_OFFSET) qd_hi = r.data_byte;
                  if (hdr_off == dqne_pkg::QDCNT_LO_OFFSET && qd_hi == 8'h00 &&
                      r.data_byte == 8'h00)
                     phase = S_IDLE;
                  hdr_off++;
                  if (r.last_byte) phase = S_IDLE;
               end else if (r.data_byte == 8'h00) begin
                  phase = S_IDLE;
               end else begin
                  phase = S_LEN;
                  take_length(r.data_byte, r.last_byte);
               end
            end
            S_LEN: take_length(r.data_byte, r.last_byte);
            S_CHARS: begin
               if (r.last_byte || name_len >= NAME_BYTES - 1) begin
                  close_name(dqne_pkg::KIND_DISCARD);
               end else begin
                  name_len++;
                  label_left--;
                  if (label_left == 0) phase = S_LEN;
                  push_result(dqne_pkg::KIND_CHAR, r.data_byte, name_len);
               end
            end
            default: phase = S_IDLE;
         endcase
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("%0t: %s", $realtime, msg);
      endfunction

      function void check_result(dqne_pkg::rsp_payload_type a);
         dqne_pkg::rsp_payload_type e;
         if (expected_q.size() == 0) begin
            flag($sformatf("unexpected result kind=%0d char=%02h len=%0d",
                           a.result_kind, a.name_char, a.name_length));
            return;
         end
         e = expected_q.pop_front();
         if (a.result_kind != e.result_kind || a.name_char != e.name_char ||
             a.name_length != e.name_length)
            flag($sformatf("exp kind=%0d char=%02h len=%0d got kind=%0d char=%02h len=%0d",
                           e.result_kind, e.name_char, e.name_length,
                           a.result_kind, a.name_char, a.name_length));
      endfunction

      function void report_leftover();
         while (expected_q.size() != 0) begin
            void'(expected_q.pop_front());
            flag("expected result never arrived");
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   dqne_req_if req_bus();
   dqne_rsp_if rsp_bus();

   dns_query_name_extractor_unit #(
      .NAME_BYTES(NAME_BYTES),
      .MAX_LABELS(MAX_LABELS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   name_scoreboard sb;
   logic [7:0]     dgram[$];
   logic [15:0]    cur_port;
   bit             no_gap;
   int             long_hold_reqs;
   int             sent_bytes;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) sb.note_byte(req_bus.payload);
         if (rsp_bus.valid && rsp_bus.ready) sb.check_result(rsp_bus.payload);
      end
   end

   // result side: bursts of steady ready, random stalls, and a long hold on each request
   initial begin
      int hold_cnt;
      int burst_cnt;
      int rsp_mode;
      int holds_done;
      hold_cnt   = 0;
      burst_cnt  = 0;
      rsp_mode   = 0;
      holds_done = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_bus.ready = 1'b0;
         end else if (holds_done < long_hold_reqs) begin
            holds_done++;
            hold_cnt = LONG_HOLD;
            rsp_bus.ready = 1'b0;
         end else begin
            if (burst_cnt == 0) begin
               rsp_mode  = $urandom_range(0, 2);
               burst_cnt = $urandom_range(20, 120);
            end
            burst_cnt--;
            case (rsp_mode)
               0: rsp_bus.ready = 1'b1;
               1: rsp_bus.ready = ($urandom_range(0, 3) != 0);
               default: begin
                  if ($urandom_range(0, 9) == 0) begin
                     rsp_bus.ready = 1'b0;
                     if ($urandom_range(0, 9) == 0) hold_cnt = $urandom_range(15, 40);
                     else hold_cnt = $urandom_range(1, 3);
                  end else begin
                     rsp_bus.ready = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gap || r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // offer one byte from a falling edge, hold it until accepted
   task automatic push_byte(logic [7:0] d, logic f, logic l, logic [15:0] p, logic [15:0] dl);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid                   = 1'b1;
      req_bus.payload.data_byte       = d;
      req_bus.payload.first_byte      = f;
      req_bus.payload.last_byte       = l;
      req_bus.payload.dest_port       = p;
      req_bus.payload.datagram_length = dl;
      do @(posedge clock); while (!req_bus.ready);
      sent_bytes++;
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic send_dgram(logic [15:0] p, logic [15:0] dl, bit close);
      int n;
      n = dgram.size();
      no_gap = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) begin
         if (i == 0) push_byte(dgram[i], 1'b1, close && n == 1, p, dl);
         else push_byte(dgram[i], 1'b0, close && i == n - 1, 16'($urandom), 16'($urandom));
      end
   endtask

   task automatic send_stray(int n);
      no_gap = 1'b0;
      repeat (n) push_byte(8'($urandom), 1'b0, $urandom_range(0, 3) == 0,
                           16'($urandom), 16'($urandom));
   endtask

   task automatic start_header(bit qr, logic [15:0] qd);
      dgram.delete();
      repeat (12) dgram.push_back(8'($urandom));
      dgram[2][7] = qr;
      dgram[4]    = qd[15:8];
      dgram[5]    = qd[7:0];
   endtask

   task automatic add_label(int len);
      dgram.push_back(len[7:0]);
      repeat (len) dgram.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic trim_to(int k);
      while (dgram.size() > k) void'(dgram.pop_back());
   endtask

   // drain outstanding results, then let bytes with no result clear the pipe
   task automatic wait_quiet();
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_dns_port(logic [15:0] v);
      wait_quiet();
      csr_wr_en   = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.port   = v;
      cur_port  = v;
   endtask

   task automatic random_dgram();
      int          r;
      int          nlab;
      int          len;
      bit          close;
      logic [15:0] p;
      logic [15:0] dl;
      logic [15:0] qd;
      r     = $urandom_range(0, 99);
      p     = cur_port;
      dl    = ($urandom_range(0, 9) == 0) ? dqne_pkg::MIN_DGRAM_LEN :
                                            16'($urandom_range(13, 65535));
      close = 1'b1;
      do qd = 16'($urandom); while (qd == 16'h0000);
      if (r >= 96 && r < 98) begin
         start_header(1'b0, qd);
         nlab = $urandom_range(63, 65);
         repeat (nlab) add_label($urandom_range(1, 2));
      end else if (r >= 98) begin
         start_header(1'b0, qd);
         repeat (3) add_label(63);
         add_label($urandom_range(55, 63));
         if ($urandom_range(0, 1) == 0) add_label(1);
      end else begin
         start_header(1'b0, qd);
         nlab = $urandom_range(1, 4);
         repeat (nlab) begin
            if ($urandom_range(0, 19) == 0) len = $urandom_range(13, 63);
            else len = $urandom_range(1, 12);
            add_label(len);
         end
      end
      dgram.push_back(8'h00);

      if (r < 60) begin
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 2)) dgram.push_back(8'($urandom));
      end else if (r < 68) begin
         trim_to($urandom_range(13, dgram.size() - 1));
      end else if (r < 73) begin
         close = 1'b0;
      end else if (r < 77) begin
         do p = 16'($urandom); while (p == cur_port);
      end else if (r < 80) begin
         dl = 16'($urandom_range(0, 12));
      end else if (r < 83) begin
         dgram[2][7] = 1'b1;
      end else if (r < 86) begin
         dgram[4] = 8'h00;
         dgram[5] = 8'h00;
      end else if (r < 89) begin
         dgram[12] = 8'h00;
      end else if (r < 93) begin
         dgram[12] = 8'($urandom_range(64, 255));
      end else if (r < 95) begin
         trim_to($urandom_range(1, 12));
      end else if (r < 96) begin
         send_stray($urandom_range(1, 5));
         return;
      end
      send_dgram(p, dl, close);
   endtask

   initial begin
      logic [15:0] phase_ports[4];
      int          base_bytes;
      sb             = new();
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = 16'h0000;
      req_bus.valid  = 1'b0;
      req_bus.payload = '0;
      no_gap         = 1'b0;
      long_hold_reqs = 0;
      sent_bytes     = 0;
      cur_port       = dqne_pkg::DNS_PORT_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed cases at the reset port value
      send_stray(2);
      start_header(1'b0, 16'h0001); add_label(1); dgram.push_back(8'h00);
      send_dgram(dqne_pkg::DNS_PORT_RESET, dqne_pkg::MIN_DGRAM_LEN, 1'b1);
      start_header(1'b0, 16'h0100); add_label(63); dgram.push_back(8'h00);
      dgram.push_back(8'hFF);
      send_dgram(dqne_pkg::DNS_PORT_RESET, 16'hFFFF, 1'b1);
      start_header(1'b0, 16'h0001); dgram.push_back(8'd64);
      send_dgram(dqne_pkg::DNS_PORT_RESET, 16'd100, 1'b1);
      start_header(1'b0, 16'hFFFF); add_label(2); dgram.push_back(8'hFF);
      send_dgram(dqne_pkg::DNS_PORT_RESET, 16'd100, 1'b1);
      start_header(1'b0, 16'h0001); dgram.push_back(8'h00); dgram.push_back(8'h05);
      send_dgram(dqne_pkg::DNS_PORT_RESET, 16'd20, 1'b1);
      start_header(1'b1, 16'h0001); add_label(3); dgram.push_back(8'h00);
      send_dgram(dqne_pkg::DNS_PORT_RESET, 16'd20, 1'b1);
      start_header(1'b0, 16'h0000); add_label(3); dgram.push_back(8'h00);
      send_dgram(dqne_pkg::DNS_PORT_RESET, 16'd20, 1'b1);
      start_header(1'b0, 16'h0001); add_label(3); dgram.push_back(8'h00);
      send_dgram(dqne_pkg::DNS_PORT_RESET + 16'd1, 16'd20, 1'b1);
      send_dgram(dqne_pkg::DNS_PORT_RESET, 16'd12, 1'b1);
      trim_to(6);
      send_dgram(dqne_pkg::DNS_PORT_RESET, 16'd20, 1'b1);
      dgram.delete(); dgram.push_back(8'h00);
      send_dgram(dqne_pkg::DNS_PORT_RESET, dqne_pkg::MIN_DGRAM_LEN, 1'b1);
      // early end on a character, then on a nonzero length byte
      start_header(1'b0, 16'h0001); add_label(4); trim_to(14);
      send_dgram(dqne_pkg::DNS_PORT_RESET, 16'd20, 1'b1);
      start_header(1'b0, 16'h0001); add_label(2); dgram.push_back(8'h03);
      send_dgram(dqne_pkg::DNS_PORT_RESET, 16'd20, 1'b1);
      // open name abandoned by the next first byte
      start_header(1'b0, 16'h0001); add_label(5);
      send_dgram(dqne_pkg::DNS_PORT_RESET, 16'd20, 1'b0);
      start_header(1'b0, 16'h8000); add_label(2); dgram.push_back(8'h00);
      send_dgram(dqne_pkg::DNS_PORT_RESET, 16'd20, 1'b1);
      // label count limit
      start_header(1'b0, 16'h0001); repeat (MAX_LABELS - 1) add_label(1);
      dgram.push_back(8'h00);
      send_dgram(dqne_pkg::DNS_PORT_RESET, 16'd200, 1'b1);
      start_header(1'b0, 16'h0001); repeat (MAX_LABELS) add_label(1);
      dgram.push_back(8'h00);
      send_dgram(dqne_pkg::DNS_PORT_RESET, 16'd200, 1'b1);
      // name length limit, hit on a character and on a separator, and a full name accepted
      start_header(1'b0, 16'h0001); repeat (4) add_label(63); dgram.push_back(8'h00);
      send_dgram(dqne_pkg::DNS_PORT_RESET, 16'd300, 1'b1);
      start_header(1'b0, 16'h0001); repeat (3) add_label(63);
      add_label(59); add_label(1); add_label(1); dgram.push_back(8'h00);
      send_dgram(dqne_pkg::DNS_PORT_RESET, 16'd300, 1'b1);
      start_header(1'b0, 16'h0001); repeat (3) add_label(63);
      add_label(61); dgram.push_back(8'h00);
      send_dgram(dqne_pkg::DNS_PORT_RESET, 16'd300, 1'b1);

      // random traffic over several port settings
      phase_ports[0] = 16'hFFFF;
      phase_ports[1] = 16'h0000;
      phase_ports[2] = 16'($urandom);
      phase_ports[3] = dqne_pkg::DNS_PORT_RESET;
      base_bytes = sent_bytes;
      for (int ph = 0; ph < 4; ph++) begin
         write_dns_port(phase_ports[ph]);
         if (ph == 0 || ph == 2) long_hold_reqs++;
         while (sent_bytes < base_bytes + (ph + 1) * (ITEM_TARGET - base_bytes) / 4)
            random_dgram();
      end

      wait_quiet();
      sb.report_leftover();
      if (sb.errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
